// File: src/horn_forward_chaining_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the forward-chaining engine
// Shared wrappers for the concurrent checks on the ports.
// ----------------------------------------------------------------------------
`ifndef HORN_FORWARD_CHAINING_ASSERT_SVH
`define HORN_FORWARD_CHAINING_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define HFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define HFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/hfc_pkg.sv
// ----------------------------------------------------------------------------
// Forward-chaining engine package
// Opcodes, clause modes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package hfc_pkg;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned LIT_W       = 10;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [1:0] {
    OP_FACT  = 2'd0,
    OP_HEAD  = 2'd1,
    OP_BODY  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_ACTIVE  = 2'd1,
    MODE_INERT   = 2'd2,
    MODE_DISCARD = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PRE,
    S_EXEC,
    S_LINK,
    S_CLOSE,
    S_QPOP,
    S_QFRONT,
    S_QLIT,
    S_QWALK,
    S_QOCC,
    S_QCL,
    S_RESP
  } state_e;

endpackage

// File: src/hfc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/horn_forward_chaining.sv
// ----------------------------------------------------------------------------
// Horn-clause forward-chaining engine
// Incremental loader and query engine for definite clauses over symbols.
// ----------------------------------------------------------------------------
// Every input transaction carries an opcode (add a fact, open a clause with
// its head, add a body literal, or query), a symbol and a last flag, and
// produces exactly one result transaction holding the query answer and a
// status bit that reports a full store, a full queue or a symbol out of
// range. After reset the engine clears its symbol table and accepts no
// input in that time. Work is one item at a time through a single
// sequencer around five RAMs with registered read data (symbol table,
// occurrence clause, occurrence link, clause table, pending queue). A fact,
// head or body item goes through the pre-check, execute and result states,
// with a link state when a body literal is appended behind an existing list
// entry and a close state when the item closes a clause. A query answered
// at once takes the same path. Otherwise it visits a queue-count check for
// each pop, a look at each entry at the queue front, a lookup of that
// entry's symbol, and, for a symbol whose list is walked, a step per list
// position plus an occurrence read and a clause update per occurrence,
// since each step waits on one RAM read. The result sits in an output
// register, so the next item is taken while it waits to be read.
module horn_forward_chaining #(
  parameter int unsigned LITERAL_COUNT    = 1024,
  parameter int unsigned CLAUSE_COUNT     = 1024,
  parameter int unsigned OCCURRENCE_COUNT = 4096,
  parameter int unsigned QUEUE_DEPTH      = 1024,
  parameter int unsigned MAX_BODY         = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [1:0] op, [11:2] literal, [15:12] zero
  input  logic [hfc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] entailed, [1] status, [7:2] zero
  output logic [hfc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  // Widths of the stores and their pointers.
  localparam int unsigned LW   = $clog2(LITERAL_COUNT);
  localparam int unsigned OW   = $clog2(OCCURRENCE_COUNT + 1);
  localparam int unsigned OAW  = (OCCURRENCE_COUNT > 1) ? $clog2(OCCURRENCE_COUNT) : 1;
  localparam int unsigned CAW  = (CLAUSE_COUNT > 1) ? $clog2(CLAUSE_COUNT) : 1;
  localparam int unsigned CFW  = $clog2(CLAUSE_COUNT + 1);
  localparam int unsigned QAW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PW   = $clog2(MAX_BODY + 1);
  localparam int unsigned LWW  = 1 + 2 * OW;
  localparam int unsigned CWW  = hfc_pkg::LIT_W + PW;
  localparam logic [OW-1:0] LINK_NULL = OW'(OCCURRENCE_COUNT);

  // Sequencer and item registers.
  hfc_pkg::state_e state_q, state_d;
  hfc_pkg::op_e    op_q, op_d;
  hfc_pkg::mode_e  mode_q, mode_d;
  logic [hfc_pkg::LIT_W-1:0] lit_q, lit_d;
  logic                      last_q, last_d;
  logic                      ent_q, ent_d;
  logic                      st_q, st_d;
  logic                      found_q, found_d;
  logic [LW-1:0]             clr_q, clr_d;

  // Open clause, fill levels and queue pointers.
  logic [CAW-1:0]            open_clause_q, open_clause_d;
  logic [hfc_pkg::LIT_W-1:0] open_head_q, open_head_d;
  logic [PW-1:0]             open_pend_q, open_pend_d;
  logic [CFW-1:0]            clause_fill_q, clause_fill_d;
  logic [OW-1:0]             occ_fill_q, occ_fill_d;
  logic [QAW-1:0]            q_rd_q, q_rd_d;
  logic [QAW-1:0]            q_wr_q, q_wr_d;
  logic [QCW-1:0]            q_cnt_q, q_cnt_d;

  // List append and list walk.
  logic [OW-1:0]             link_addr_q, link_addr_d;
  logic [OW-1:0]             link_slot_q, link_slot_d;
  logic [OW-1:0]             walk_p_q, walk_p_d;
  logic [OW-1:0]             walk_next_q, walk_next_d;
  logic [CAW-1:0]            walk_c_q, walk_c_d;
  logic [hfc_pkg::LIT_W-1:0] fq_q, fq_d;

  // Output register.
  logic out_valid_q, out_valid_d;
  logic out_ent_q, out_ent_d;
  logic out_st_q, out_st_d;

  // RAM ports.
  logic               lit_we;
  logic [LW-1:0]      lit_waddr, lit_raddr;
  logic [LWW-1:0]     lit_wdata, lit_rdata;
  logic               occ_we, link_we;
  logic [OAW-1:0]     occ_waddr, link_waddr, occ_raddr;
  logic [CAW-1:0]     occ_wdata, occ_rdata;
  logic [OW-1:0]      link_wdata, link_rdata;
  logic               cl_we;
  logic [CAW-1:0]     cl_waddr, cl_raddr;
  logic [CWW-1:0]     cl_wdata, cl_rdata;
  logic               q_we;
  logic [QAW-1:0]     q_waddr;
  logic [hfc_pkg::LIT_W-1:0] q_wdata, q_rdata;

  // Combinational helpers.
  logic                      s_acc;
  logic                      lit_oor, f_oor;
  logic                      lit_inf;
  logic [OW-1:0]             lit_first, lit_last;
  logic [hfc_pkg::LIT_W-1:0] cl_head;
  logic [PW-1:0]             cl_pend;
  logic                      body_link;
  logic                      do_close;
  logic                      push_req;
  logic [hfc_pkg::LIT_W-1:0] push_val;
  logic                      resp_load;

  assign s_axis_tready = (state_q == hfc_pkg::S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_st_q, out_ent_q};

  assign lit_oor   = (32'(lit_q) >= LITERAL_COUNT);
  assign f_oor     = (32'(q_rdata) >= LITERAL_COUNT);
  assign lit_inf   = lit_rdata[LWW-1];
  assign lit_first = lit_rdata[2*OW-1:OW];
  assign lit_last  = lit_rdata[OW-1:0];
  assign cl_head   = cl_rdata[CWW-1:PW];
  assign cl_pend   = cl_rdata[PW-1:0];
  assign resp_load = (state_q == hfc_pkg::S_RESP) && (!out_valid_q || m_axis_tready);

  // A body literal appended behind an existing list entry needs a second
  // write into the link store, done in its own cycle.
  assign body_link = (op_q == hfc_pkg::OP_BODY) && (mode_q == hfc_pkg::MODE_ACTIVE) &&
                     !lit_oor && !lit_inf && (occ_fill_q != LINK_NULL) &&
                     (open_pend_q != PW'(MAX_BODY)) && (lit_first != LINK_NULL);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      hfc_pkg::S_CLEAR: begin
        if (clr_q == LW'(LITERAL_COUNT - 1)) state_d = hfc_pkg::S_IDLE;
      end
      hfc_pkg::S_IDLE: begin
        if (s_acc) state_d = hfc_pkg::S_PRE;
      end
      hfc_pkg::S_PRE: state_d = hfc_pkg::S_EXEC;
      hfc_pkg::S_EXEC: begin
        case (op_q)
          hfc_pkg::OP_FACT: state_d = hfc_pkg::S_RESP;
          hfc_pkg::OP_HEAD: state_d = last_q ? hfc_pkg::S_CLOSE : hfc_pkg::S_RESP;
          hfc_pkg::OP_BODY: begin
            if (mode_q == hfc_pkg::MODE_NONE) state_d = hfc_pkg::S_RESP;
            else if (body_link)               state_d = hfc_pkg::S_LINK;
            else if (last_q)                  state_d = hfc_pkg::S_CLOSE;
            else                              state_d = hfc_pkg::S_RESP;
          end
          default: begin
            state_d = (lit_oor || lit_inf) ? hfc_pkg::S_RESP : hfc_pkg::S_QPOP;
          end
        endcase
      end
      hfc_pkg::S_LINK:  state_d = last_q ? hfc_pkg::S_CLOSE : hfc_pkg::S_RESP;
      hfc_pkg::S_CLOSE: state_d = hfc_pkg::S_RESP;
      hfc_pkg::S_QPOP: begin
        state_d = (q_cnt_q == '0) ? hfc_pkg::S_RESP : hfc_pkg::S_QFRONT;
      end
      hfc_pkg::S_QFRONT: begin
        if (q_rdata == lit_q) state_d = hfc_pkg::S_RESP;
        else if (f_oor)       state_d = hfc_pkg::S_QPOP;
        else                  state_d = hfc_pkg::S_QLIT;
      end
      hfc_pkg::S_QLIT: state_d = lit_inf ? hfc_pkg::S_QPOP : hfc_pkg::S_QWALK;
      hfc_pkg::S_QWALK: begin
        if (walk_p_q != LINK_NULL) state_d = hfc_pkg::S_QOCC;
        else if (found_q)          state_d = hfc_pkg::S_RESP;
        else                       state_d = hfc_pkg::S_QPOP;
      end
      hfc_pkg::S_QOCC: state_d = hfc_pkg::S_QCL;
      hfc_pkg::S_QCL:  state_d = hfc_pkg::S_QWALK;
      hfc_pkg::S_RESP: begin
        if (resp_load) state_d = hfc_pkg::S_IDLE;
      end
      default: state_d = hfc_pkg::S_IDLE;
    endcase
  end

  // Datapath, store accesses and queue bookkeeping.
  always_comb begin
    op_d          = op_q;
    mode_d        = mode_q;
    lit_d         = lit_q;
    last_d        = last_q;
    ent_d         = ent_q;
    st_d          = st_q;
    found_d       = found_q;
    clr_d         = clr_q;
    open_clause_d = open_clause_q;
    open_head_d   = open_head_q;
    open_pend_d   = open_pend_q;
    clause_fill_d = clause_fill_q;
    occ_fill_d    = occ_fill_q;
    q_rd_d        = q_rd_q;
    q_wr_d        = q_wr_q;
    q_cnt_d       = q_cnt_q;
    link_addr_d   = link_addr_q;
    link_slot_d   = link_slot_q;
    walk_p_d      = walk_p_q;
    walk_next_d   = walk_next_q;
    walk_c_d      = walk_c_q;
    fq_d          = fq_q;

    lit_we     = 1'b0;
    lit_waddr  = LW'(lit_q);
    lit_wdata  = {1'b0, LINK_NULL, LINK_NULL};
    lit_raddr  = LW'(lit_q);
    occ_we     = 1'b0;
    occ_waddr  = occ_fill_q[OAW-1:0];
    occ_wdata  = open_clause_q;
    link_we    = 1'b0;
    link_waddr = occ_fill_q[OAW-1:0];
    link_wdata = LINK_NULL;
    occ_raddr  = walk_p_q[OAW-1:0];
    cl_we      = 1'b0;
    cl_waddr   = open_clause_q;
    cl_wdata   = {open_head_q, open_pend_q};
    cl_raddr   = occ_rdata;
    q_we       = 1'b0;
    q_waddr    = q_wr_q;
    q_wdata    = open_head_q;

    do_close = 1'b0;
    push_req = 1'b0;
    push_val = open_head_q;

    case (state_q)
      hfc_pkg::S_CLEAR: begin
        lit_we    = 1'b1;
        lit_waddr = clr_q;
        clr_d     = clr_q + LW'(1);
      end
      hfc_pkg::S_IDLE: begin
        if (s_acc) begin
          op_d   = hfc_pkg::op_e'(s_axis_tdata[hfc_pkg::OP_W-1:0]);
          lit_d  = s_axis_tdata[hfc_pkg::OP_W +: hfc_pkg::LIT_W];
          last_d = s_axis_tlast;
          ent_d  = 1'b0;
          st_d   = 1'b0;
        end
      end
      hfc_pkg::S_PRE: begin
        // Anything but a body literal first closes a clause left open.
        do_close = (op_q != hfc_pkg::OP_BODY) && (mode_q != hfc_pkg::MODE_NONE);
      end
      hfc_pkg::S_EXEC: begin
        case (op_q)
          hfc_pkg::OP_FACT: begin
            if (lit_oor) begin
              st_d = 1'b1;
            end else begin
              push_req = 1'b1;
              push_val = lit_q;
            end
          end
          hfc_pkg::OP_HEAD: begin
            if (lit_oor || (clause_fill_q == CFW'(CLAUSE_COUNT))) begin
              mode_d = hfc_pkg::MODE_DISCARD;
              st_d   = 1'b1;
            end else begin
              open_clause_d = clause_fill_q[CAW-1:0];
              clause_fill_d = clause_fill_q + CFW'(1);
              open_head_d   = lit_q;
              open_pend_d   = '0;
              mode_d        = lit_inf ? hfc_pkg::MODE_INERT : hfc_pkg::MODE_ACTIVE;
            end
          end
          hfc_pkg::OP_BODY: begin
            if (mode_q == hfc_pkg::MODE_ACTIVE) begin
              if (lit_oor) begin
                st_d = 1'b1;
              end else if (!lit_inf) begin
                if ((occ_fill_q == LINK_NULL) || (open_pend_q == PW'(MAX_BODY))) begin
                  st_d = 1'b1;
                end else begin
                  // New occurrence at the fill point, appended to the list.
                  occ_we      = 1'b1;
                  link_we     = 1'b1;
                  occ_fill_d  = occ_fill_q + OW'(1);
                  open_pend_d = open_pend_q + PW'(1);
                  lit_we      = 1'b1;
                  lit_wdata   = {1'b0, (lit_first == LINK_NULL) ? occ_fill_q : lit_first,
                                 occ_fill_q};
                  link_addr_d = lit_last;
                  link_slot_d = occ_fill_q;
                end
              end
            end
          end
          default: begin
            found_d = 1'b0;
            if (!lit_oor && lit_inf) ent_d = 1'b1;
          end
        endcase
      end
      hfc_pkg::S_LINK: begin
        link_we    = 1'b1;
        link_waddr = link_addr_q[OAW-1:0];
        link_wdata = link_slot_q;
      end
      hfc_pkg::S_CLOSE: begin
        do_close = 1'b1;
      end
      hfc_pkg::S_QFRONT: begin
        fq_d      = q_rdata;
        lit_raddr = LW'(q_rdata);
        if (q_rdata == lit_q) begin
          // The query sits at the queue front: answered, entry stays.
          ent_d = 1'b1;
        end else begin
          q_rd_d  = (q_rd_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : q_rd_q + QAW'(1);
          q_cnt_d = q_cnt_q - QCW'(1);
        end
      end
      hfc_pkg::S_QLIT: begin
        walk_p_d = lit_first;
      end
      hfc_pkg::S_QWALK: begin
        if (walk_p_q == LINK_NULL) begin
          // End of list: the popped symbol becomes inferred, list released.
          lit_we    = 1'b1;
          lit_waddr = LW'(fq_q);
          lit_wdata = {1'b1, LINK_NULL, LINK_NULL};
          if (found_q) ent_d = 1'b1;
        end
      end
      hfc_pkg::S_QOCC: begin
        walk_c_d    = occ_rdata;
        walk_next_d = link_rdata;
      end
      hfc_pkg::S_QCL: begin
        walk_p_d = walk_next_q;
        if (cl_pend != '0) begin
          cl_we    = 1'b1;
          cl_waddr = walk_c_q;
          cl_wdata = {cl_head, cl_pend - PW'(1)};
          if (cl_pend == PW'(1)) begin
            push_req = 1'b1;
            push_val = cl_head;
            if (cl_head == lit_q) found_d = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (do_close) begin
      mode_d = hfc_pkg::MODE_NONE;
      if (mode_q == hfc_pkg::MODE_ACTIVE) begin
        cl_we = 1'b1;
        if (open_pend_q == '0) push_req = 1'b1;
      end
    end

    // Pushes never share a cycle with a pop.
    if (push_req) begin
      if (q_cnt_q == QCW'(QUEUE_DEPTH)) begin
        st_d = 1'b1;
      end else begin
        q_we    = 1'b1;
        q_wdata = push_val;
        q_wr_d  = (q_wr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : q_wr_q + QAW'(1);
        q_cnt_d = q_cnt_q + QCW'(1);
      end
    end
  end

  // Output register: holds a result until the downstream side takes it.
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_ent_d   = out_ent_q;
    out_st_d    = out_st_q;
    if (resp_load) begin
      out_valid_d = 1'b1;
      out_ent_d   = ent_q;
      out_st_d    = st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= hfc_pkg::S_CLEAR;
      mode_q        <= hfc_pkg::MODE_NONE;
      clr_q         <= '0;
      clause_fill_q <= '0;
      occ_fill_q    <= '0;
      q_rd_q        <= '0;
      q_wr_q        <= '0;
      q_cnt_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      mode_q        <= mode_d;
      clr_q         <= clr_d;
      clause_fill_q <= clause_fill_d;
      occ_fill_q    <= occ_fill_d;
      q_rd_q        <= q_rd_d;
      q_wr_q        <= q_wr_d;
      q_cnt_q       <= q_cnt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    lit_q         <= lit_d;
    last_q        <= last_d;
    ent_q         <= ent_d;
    st_q          <= st_d;
    found_q       <= found_d;
    open_clause_q <= open_clause_d;
    open_head_q   <= open_head_d;
    open_pend_q   <= open_pend_d;
    link_addr_q   <= link_addr_d;
    link_slot_q   <= link_slot_d;
    walk_p_q      <= walk_p_d;
    walk_next_q   <= walk_next_d;
    walk_c_q      <= walk_c_d;
    fq_q          <= fq_d;
    out_ent_q     <= out_ent_d;
    out_st_q      <= out_st_d;
  end

  // Symbol table: inferred flag, list head and list tail per symbol.
  hfc_ram #(.WIDTH(LWW), .DEPTH(LITERAL_COUNT)) u_lit_ram (
    .clk_i   (clk_i),
    .we_i    (lit_we),
    .waddr_i (lit_waddr),
    .wdata_i (lit_wdata),
    .raddr_i (lit_raddr),
    .rdata_o (lit_rdata)
  );

  hfc_ram #(.WIDTH(CAW), .DEPTH(OCCURRENCE_COUNT)) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .waddr_i (occ_waddr),
    .wdata_i (occ_wdata),
    .raddr_i (occ_raddr),
    .rdata_o (occ_rdata)
  );

  hfc_ram #(.WIDTH(OW), .DEPTH(OCCURRENCE_COUNT)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (occ_raddr),
    .rdata_o (link_rdata)
  );

  hfc_ram #(.WIDTH(CWW), .DEPTH(CLAUSE_COUNT)) u_clause_ram (
    .clk_i   (clk_i),
    .we_i    (cl_we),
    .waddr_i (cl_waddr),
    .wdata_i (cl_wdata),
    .raddr_i (cl_raddr),
    .rdata_o (cl_rdata)
  );

  hfc_ram #(.WIDTH(hfc_pkg::LIT_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_rd_q),
    .rdata_o (q_rdata)
  );

endmodule

// File: src/hfc_checker.sv
// ----------------------------------------------------------------------------
// Forward-chaining engine port checker
// Checks ordering of input and result transactions seen at the ports.
// ----------------------------------------------------------------------------
`include "horn_forward_chaining_assert.svh"

module hfc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [hfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic       s_acc, m_acc;
  logic [1:0] outstanding_q;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  // Items taken whose result has not yet been delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_q + 2'(s_acc) - 2'(m_acc);
    end
  end

  `HFC_ASSERT_NOW(a_no_spurious_result, m_axis_tvalid, outstanding_q != 2'd0, "result without item")
  `HFC_ASSERT_NOW(a_bounded_backlog, s_acc, outstanding_q <= 2'd1, "too many items in flight")
  `HFC_ASSERT_NEXT(a_one_at_a_time, s_acc, !s_axis_tready, "item taken while busy")
  `HFC_ASSERT_NEXT(a_result_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind horn_forward_chaining hfc_checker u_hfc_checker (.*);
